/* hw/rtl/bgi_pkg.sv */
// Shared types and constants for the breakpoint gain interpolator.
// No dependencies; imported by every module of the block.
package bgi_pkg;

    localparam int X_W        = 32;
    localparam int Y_W        = 16;
    localparam int IDX_IN_W   = 4;
    localparam int CFG_W      = 5;

    localparam int S_TDATA_W  = 104;
    localparam int M_TDATA_W  = 40;

    localparam int PROD_W     = 48;
    localparam int MUL_STEPS  = 16;
    localparam int DIV_STEPS  = 48;
    localparam int MUL_CNT_W  = $clog2(MUL_STEPS + 1);
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [Y_W-1:0]   ONE_Q15   = 16'd32768;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd2;
    localparam logic [17:0]      QUO_CAP   = 18'h20000;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HI,
        ST_LO,
        ST_SCAN,
        ST_PREP,
        ST_ABS,
        ST_MUL,
        ST_DIV,
        ST_SUM,
        ST_GSTART,
        ST_GAIN,
        ST_DONE
    } bgi_state_t;

endpackage

/* hw/rtl/bgi_smul.sv */
// Bit-serial unsigned multiplier, one multiplier bit per cycle.
// Depends on bgi_pkg for widths and step count.
module bgi_smul
    import bgi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [X_W-1:0]    mcand,
    input  logic [Y_W-1:0]    mplier,
    output logic              done,
    output logic [PROD_W-1:0] product
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [PROD_W-1:0]    acc_reg;
    logic [PROD_W-1:0]    mcand_reg;
    logic [Y_W-1:0]       mplier_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= MUL_CNT_W'(MUL_STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == MUL_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= PROD_W'(mcand);
            mplier_reg <= mplier;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[PROD_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[Y_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

/* hw/rtl/bgi_sdiv.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on bgi_pkg for widths and step count.
module bgi_sdiv
    import bgi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [X_W-1:0]    divisor,
    output logic              done,
    output logic [PROD_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [X_W-1:0]       rem_reg;
    logic [PROD_W-1:0]    quo_reg;
    logic [X_W-1:0]       dvs_reg;
    logic [X_W:0]         partial;
    logic [X_W+1:0]       diff;

    assign partial = {rem_reg, quo_reg[PROD_W-1]};
    assign diff    = {1'b0, partial} - {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[X_W+1])
            begin
                rem_reg <= diff[X_W-1:0];
                quo_reg <= {quo_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= partial[X_W-1:0];
                quo_reg <= {quo_reg[PROD_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hw/rtl/breakpoint_gain_interpolator_core.sv */
// Breakpoint gain interpolator: table memory, segment search and control.
// Depends on bgi_pkg, bgi_smul and bgi_sdiv.
//
// Usage:
//   s_axis carries input words; tuser is the kind (load or evaluate).
//   A load word writes one breakpoint (x, y).
//   An evaluate word clamps its sample to the table range, searches the
//   segments one breakpoint per cycle from the table memory, forms the
//   slope term with a bit-serial multiply and a bit-serial restoring
//   divide, then scales gain_in with a second bit-serial multiply.
//   One word is worked on at a time. A zero-width segment skips the divide.
//   m_axis carries one result word per evaluate word, none per load word.
//   The output register holds a result while m_axis_tready is low; the
//   next word is accepted meanwhile and its result waits until it frees.
//   cfg_we writes point_count; the block leaves it to the user to write only while the block is idle.
//   Reset sets point_count to 2 and empties the output; table contents
//   are undefined until loaded.
module breakpoint_gain_interpolator_core
    import bgi_pkg::*;
#(
    parameter int MAX_POINTS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_wdata,     // point_count
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // point_index[3:0], point_x[35:4], point_y[51:36], sample_x[83:52],
    // gain_in[99:84], zero pad[103:100]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tuser,  // kind
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // gain_out[15:0], curve_value[31:16], audible[32], zero pad[39:33]
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CW    = ($clog2(MAX_POINTS + 1) > CFG_W) ? $clog2(MAX_POINTS + 1) : CFG_W;

    bgi_state_t state_reg, state_next;

    logic [CFG_W-1:0]  cfg_reg;
    logic [X_W-1:0]    x_mem [MAX_POINTS];
    logic [Y_W-1:0]    y_mem [MAX_POINTS];
    logic [X_W-1:0]    rd_x_reg;
    logic [Y_W-1:0]    rd_y_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              mem_we;

    logic [IDX_IN_W-1:0] in_index;
    logic [X_W-1:0]      in_px;
    logic [Y_W-1:0]      in_py;
    logic [X_W-1:0]      in_sx;
    logic [Y_W-1:0]      in_gain;
    logic [Y_W-1:0]      py_sat;
    logic [Y_W-1:0]      gain_sat;

    logic [CW-1:0]     pc_ext;
    logic [CW-1:0]     n_act;
    logic [IDX_W-1:0]  last_idx;

    logic [X_W-1:0]    sample_reg;
    logic [Y_W-1:0]    gain_reg;
    logic [X_W-1:0]    hi_reg;
    logic [X_W-1:0]    c_reg;
    logic [X_W-1:0]    x0_reg;
    logic [X_W-1:0]    x1_reg;
    logic [Y_W-1:0]    y0_reg;
    logic [Y_W-1:0]    y1_reg;
    logic [IDX_W-1:0]  i_reg;
    logic [X_W:0]      dv_reg;
    logic [X_W:0]      dx_reg;
    logic [Y_W:0]      dy_reg;
    logic [X_W-1:0]    dx_mag_reg;
    logic              neg_reg;
    logic              dxz_reg;
    logic [Y_W-1:0]    curve_reg;

    logic [X_W-1:0]    c_lo;
    logic [X_W-1:0]    c_clamp;
    logic              seg_hit;
    logic [X_W:0]      dv_abs;
    logic [Y_W:0]      dy_abs;
    logic [X_W:0]      dx_abs;
    logic [17:0]       q_cap;
    logic [19:0]       q_signed;
    logic signed [19:0] sum;
    logic [Y_W-1:0]    sum_sat;

    logic              mul_start;
    logic [X_W-1:0]    mul_a;
    logic [Y_W-1:0]    mul_b;
    logic              mul_done;
    logic [PROD_W-1:0] mul_p;
    logic              div_start;
    logic              div_done;
    logic [PROD_W-1:0] div_q;

    logic              s_accept;
    logic              out_load;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [Y_W-1:0]    out_gain_reg;
    logic [Y_W-1:0]    out_curve_reg;
    logic              out_aud_reg;

    assign in_index = s_axis_tdata[3:0];
    assign in_px    = s_axis_tdata[35:4];
    assign in_py    = s_axis_tdata[51:36];
    assign in_sx    = s_axis_tdata[83:52];
    assign in_gain  = s_axis_tdata[99:84];
    assign py_sat   = (in_py > ONE_Q15) ? ONE_Q15 : in_py;
    assign gain_sat = (in_gain > ONE_Q15) ? ONE_Q15 : in_gain;

    assign pc_ext   = CW'(cfg_reg);
    assign n_act    = (pc_ext < CW'(2)) ? CW'(2) :
                      (pc_ext > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : pc_ext;
    assign last_idx = IDX_W'(n_act - CW'(1));

    assign s_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            cfg_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            x_mem[IDX_W'(in_index)] <= in_px;
            y_mem[IDX_W'(in_index)] <= py_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_x_reg <= x_mem[rd_addr];
        rd_y_reg <= y_mem[rd_addr];
    end

    assign c_lo    = ($signed(sample_reg) <= $signed(rd_x_reg)) ? rd_x_reg : sample_reg;
    assign c_clamp = ($signed(c_lo) > $signed(hi_reg)) ? hi_reg : c_lo;
    assign seg_hit = ($signed(c_reg) >= $signed(x0_reg)) && ($signed(c_reg) < $signed(rd_x_reg));

    assign dv_abs = dv_reg[X_W] ? (~dv_reg + 1'b1) : dv_reg;
    assign dy_abs = dy_reg[Y_W] ? (~dy_reg + 1'b1) : dy_reg;
    assign dx_abs = dx_reg[X_W] ? (~dx_reg + 1'b1) : dx_reg;

    assign q_cap    = (|div_q[PROD_W-1:17]) ? QUO_CAP : div_q[17:0];
    assign q_signed = neg_reg ? (~{2'b00, q_cap} + 1'b1) : {2'b00, q_cap};
    assign sum      = $signed({4'b0000, y0_reg}) + $signed(q_signed);
    assign sum_sat  = (sum < 0) ? '0 :
                      (sum > $signed({4'b0000, ONE_Q15})) ? ONE_Q15 : sum[Y_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        rd_addr       = '0;
        mem_we        = 1'b0;
        s_axis_tready = 1'b0;
        mul_start     = 1'b0;
        mul_a         = dv_abs[X_W-1:0];
        mul_b         = dy_abs[Y_W-1:0];
        div_start     = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                rd_addr       = last_idx;
                if (s_accept)
                begin
                    if (s_axis_tuser == KIND_EVAL)
                    begin
                        state_next = ST_HI;
                    end
                    else
                    begin
                        mem_we = (32'(in_index) < 32'(MAX_POINTS));
                    end
                end
            end
            ST_HI:
            begin
                rd_addr    = '0;
                state_next = ST_LO;
            end
            ST_LO:
            begin
                rd_addr    = IDX_W'(1);
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                rd_addr = IDX_W'(i_reg + 1'b1);
                if (seg_hit || (i_reg == last_idx))
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                mul_start  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    if (dxz_reg)
                    begin
                        state_next = ST_GSTART;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                state_next = ST_GSTART;
            end
            ST_GSTART:
            begin
                mul_start  = 1'b1;
                mul_a      = X_W'(gain_reg);
                mul_b      = curve_reg;
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                if (mul_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                sample_reg <= in_sx;
                gain_reg   <= gain_sat;
            end
            ST_HI:
            begin
                hi_reg <= rd_x_reg;
            end
            ST_LO:
            begin
                c_reg  <= c_clamp;
                x0_reg <= rd_x_reg;
                y0_reg <= rd_y_reg;
                i_reg  <= IDX_W'(1);
            end
            ST_SCAN:
            begin
                if (seg_hit || (i_reg == last_idx))
                begin
                    x1_reg <= rd_x_reg;
                    y1_reg <= rd_y_reg;
                end
                else
                begin
                    x0_reg <= rd_x_reg;
                    y0_reg <= rd_y_reg;
                    i_reg  <= IDX_W'(i_reg + 1'b1);
                end
            end
            ST_PREP:
            begin
                dv_reg <= {c_reg[X_W-1], c_reg} - {x0_reg[X_W-1], x0_reg};
                dx_reg <= {x1_reg[X_W-1], x1_reg} - {x0_reg[X_W-1], x0_reg};
                dy_reg <= {1'b0, y1_reg} - {1'b0, y0_reg};
            end
            ST_ABS:
            begin
                dx_mag_reg <= dx_abs[X_W-1:0];
                neg_reg    <= dv_reg[X_W] ^ dy_reg[Y_W] ^ dx_reg[X_W];
                dxz_reg    <= (dx_reg == '0);
            end
            ST_MUL:
            begin
                if (dxz_reg)
                begin
                    curve_reg <= y0_reg;
                end
            end
            ST_SUM:
            begin
                curve_reg <= sum_sat;
            end
            default:
            begin
            end
        endcase
    end

    bgi_smul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_a),
        .mplier  (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    bgi_sdiv u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_p),
        .divisor  (dx_mag_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_gain_reg  <= mul_p[30:15];
            out_curve_reg <= curve_reg;
            out_aud_reg   <= (curve_reg != '0);
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = {7'b0000000, out_aud_reg, out_curve_reg, out_gain_reg};

endmodule
